[hw/rtl/pfa_pkg.sv]
// Package for the paged frame allocator MMU.
// Holds field widths, geometry defaults, operation and status codes.
// No dependencies; used by paged_frame_allocator_mmu.
package pfa_pkg;

  // Default geometry
  localparam int OFFSET_BITS  = 10;
  localparam int PAGE_BITS    = 5;
  localparam int SEGMENT_BITS = 5;
  localparam int NUM_FRAMES   = 1024;
  localparam int NUM_PROCS    = 16;

  // Field widths of one request and one response
  localparam int OP_W     = 2;
  localparam int PID_W    = 4;
  localparam int ADDR_W   = 20;
  localparam int SIZE_W   = 21;
  localparam int DATA_W   = 8;
  localparam int STAT_W   = 2;

  // Packed stream widths (whole bytes)
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  // Break pointer after reset
  localparam int RESET_BREAK = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_BADVA = 2'd2
  } status_t;

endpackage

[hw/rtl/pfa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Used for every table of the paged frame allocator MMU; no dependencies.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/paged_frame_allocator_mmu.sv]
// Top level of the paged frame allocator MMU: request FSM, break pointers,
// frame owner/link tables, page map and byte RAM in pfa_ram instances.
// Depends on pfa_pkg and pfa_ram.
//
//  channel | dir | handshake                 | payload
//  in_     | in  | in_tvalid / in_tready     | tuser: op; tdata: pid, address, size, write_data
//  out_    | out | out_tvalid / out_tready   | tdata: status, alloc_address, read_data
//  cfg_    | in  | cfg_wr_en                 | cfg_wr_data: initial break
//
// After reset a clearing pass zeroes the byte RAM, page map and owner table,
// one entry per cycle, over the larger of the byte RAM and page map depths; no
// request is taken during it. A write looks up the page map (S_LOOK, S_LOOKD)
// and writes the byte; a read adds S_RDD to capture it. Free walks the frame
// chain (S_FRD, S_FEV per released frame), then unmaps its pages in S_UNMAP.
// Allocate scans the owner table (S_ARD, S_AEV per frame), up to NUM_FRAMES
// frames. Each scan/walk step reads then writes the owner table (registered read).
// One request is in flight at a time; a finished result waits in the output
// register while the next request is accepted.
module paged_frame_allocator_mmu #(
  parameter int OFFSET_BITS  = pfa_pkg::OFFSET_BITS,
  parameter int PAGE_BITS    = pfa_pkg::PAGE_BITS,
  parameter int SEGMENT_BITS = pfa_pkg::SEGMENT_BITS,
  parameter int NUM_FRAMES   = pfa_pkg::NUM_FRAMES,
  parameter int NUM_PROCS    = pfa_pkg::NUM_PROCS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tuser: op[1:0]
  input  logic [pfa_pkg::OP_W-1:0]         in_tuser,
  // in_tdata: pid[3:0], address[23:4], size[44:24], write_data[52:45], zero fill
  input  logic [pfa_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: status[1:0], alloc_address[21:2], read_data[29:22], zero fill
  output logic [pfa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [pfa_pkg::ADDR_W-1:0]       cfg_wr_data
);

  localparam int FRAME_W   = $clog2(NUM_FRAMES);
  localparam int VP_W      = PAGE_BITS + SEGMENT_BITS;
  localparam int VA_W      = OFFSET_BITS + VP_W;
  localparam int PROC_W    = $clog2(NUM_PROCS);
  localparam int PM_AW     = PROC_W + VP_W;
  localparam int PM_DEPTH  = NUM_PROCS * (2 ** VP_W);
  localparam int RAM_AW    = FRAME_W + OFFSET_BITS;
  localparam int RAM_DEPTH = NUM_FRAMES * (2 ** OFFSET_BITS);
  localparam int LINK_W    = FRAME_W + 1;
  localparam int CNT_W     = FRAME_W + 1;
  localparam int BRK_W     = VA_W + 1;
  localparam int SZ_W      = pfa_pkg::SIZE_W;
  localparam int NB_W      = ((SZ_W + 1 > BRK_W) ? SZ_W + 1 : BRK_W) + 1;
  localparam int FB_W      = ((VA_W > RAM_AW) ? VA_W : RAM_AW) + 2;
  localparam int UW        = ((VP_W > CNT_W) ? VP_W : CNT_W) + 1;
  localparam int CLR_LEN   = (RAM_DEPTH > PM_DEPTH) ? RAM_DEPTH : PM_DEPTH;
  localparam int CLR_W     = $clog2(CLR_LEN);
  localparam longint RAM_BYTES = longint'(NUM_FRAMES) * (64'd1 << OFFSET_BITS);
  localparam longint VSPACE    = 64'd1 << VA_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ACHK, S_ARD, S_AEV, S_AFIN,
    S_LOOK, S_LOOKD, S_FRD, S_FEV, S_UNMAP, S_FBRK, S_RDD, S_DONE
  } state_t;

  state_t                      state_r;
  logic [CLR_W-1:0]            clr_r;
  pfa_pkg::op_t                op_r;
  logic [pfa_pkg::PID_W-1:0]   pid_r;
  logic [pfa_pkg::ADDR_W-1:0]  va_r;
  logic [SZ_W-1:0]             size_r;
  logic [pfa_pkg::DATA_W-1:0]  wd_r;
  logic [BRK_W-1:0]            brk_r [NUM_PROCS];
  logic [CNT_W-1:0]            free_r;
  logic [LINK_W-1:0]           f_r;
  logic [CNT_W-1:0]            k_r;
  logic [CNT_W-1:0]            n_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [FRAME_W-1:0]          prev_r;
  logic                        have_prev_r;
  logic [BRK_W-1:0]            ret_r;
  pfa_pkg::status_t            res_status_r;
  logic [pfa_pkg::ADDR_W-1:0]  res_addr_r;
  logic [pfa_pkg::DATA_W-1:0]  res_rd_r;
  logic                        out_tvalid_r;
  pfa_pkg::status_t            out_status_r;
  logic [pfa_pkg::ADDR_W-1:0]  out_addr_r;
  logic [pfa_pkg::DATA_W-1:0]  out_rd_r;

  // Memory ports
  logic                 own_we;
  logic [FRAME_W-1:0]   own_waddr;
  logic [PROC_W-1:0]    own_wdata;
  logic [PROC_W-1:0]    own_rdata;
  logic                 link_we;
  logic [FRAME_W-1:0]   link_waddr;
  logic [LINK_W-1:0]    link_wdata;
  logic [LINK_W-1:0]    link_rdata;
  logic                 pm_we;
  logic [PM_AW-1:0]     pm_waddr;
  logic [LINK_W-1:0]    pm_wdata;
  logic [PM_AW-1:0]     pm_raddr;
  logic [LINK_W-1:0]    pm_rdata;
  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [RAM_AW-1:0]    ram_raddr;
  logic [pfa_pkg::DATA_W-1:0] ram_wdata;
  logic [pfa_pkg::DATA_W-1:0] ram_rdata;

  // Derived request values
  logic [PROC_W-1:0]    pid_idx;
  logic [VP_W-1:0]      vpage;
  logic [BRK_W-1:0]     brk_cur;
  logic [SZ_W:0]        pad;
  logic [SZ_W:0]        n_bytes;
  logic [SZ_W:0]        n_pages;
  logic [NB_W-1:0]      nb;
  logic                 pid_bad;
  logic                 look_ok;
  logic                 look_hit;
  logic [VP_W-1:0]      vp_alloc;
  logic                 walk_take;
  logic [UW-1:0]        vp_sum;
  logic                 unmap_go;
  logic [FB_W-1:0]      fb_lhs;
  logic [FB_W-1:0]      fb_bytes;
  logic [CNT_W-1:0]     k_nxt;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 clr_last;

  assign pid_idx  = PROC_W'(pid_r);
  assign vpage    = va_r[VA_W-1:OFFSET_BITS];
  assign brk_cur  = brk_r[pid_idx];
  assign pad      = {1'b0, size_r} + (SZ_W+1)'((2 ** OFFSET_BITS) - 1);
  assign n_pages  = pad >> OFFSET_BITS;
  assign n_bytes  = n_pages << OFFSET_BITS;
  assign nb       = NB_W'(brk_cur) + NB_W'(n_bytes);
  assign pid_bad  = (pid_r == '0) || (32'(pid_r) >= NUM_PROCS);
  assign look_ok  = (32'(pid_r) < NUM_PROCS) && (64'(va_r) < VSPACE);
  assign look_hit = look_ok && pm_rdata[FRAME_W];
  assign vp_alloc = VP_W'(ret_r[BRK_W-1:OFFSET_BITS]) + VP_W'(k_r);
  assign walk_take = !f_r[FRAME_W] && (own_rdata == pid_idx);
  assign vp_sum   = UW'(vpage) + UW'(k_r);
  assign unmap_go = (k_r < cnt_r) && (vp_sum < UW'(2 ** VP_W));
  assign fb_bytes = FB_W'(cnt_r) << OFFSET_BITS;
  assign fb_lhs   = (FB_W'(vpage) << OFFSET_BITS) + fb_bytes;
  assign k_nxt    = k_r + CNT_W'(1);
  assign cnt_nxt  = cnt_r + CNT_W'(1);
  assign clr_last = ({1'b0, clr_r} == (CLR_W+1)'(CLR_LEN - 1));

  // Read addresses follow the current frame index and request
  assign pm_raddr  = {pid_idx, vpage};
  assign ram_raddr = {pm_rdata[FRAME_W-1:0], va_r[OFFSET_BITS-1:0]};
  // Sweep the clearing counter over the byte RAM after reset
  assign ram_waddr = (state_r == S_CLR) ? RAM_AW'(clr_r) : ram_raddr;

  // Memory write ports per state
  always_comb begin
    own_we     = 1'b0;
    own_waddr  = f_r[FRAME_W-1:0];
    own_wdata  = '0;
    link_we    = 1'b0;
    link_waddr = prev_r;
    link_wdata = f_r;
    pm_we      = 1'b0;
    pm_waddr   = {pid_idx, vp_alloc};
    pm_wdata   = '0;
    ram_we     = 1'b0;
    ram_wdata  = wd_r;
    unique case (state_r)
      S_CLR: begin
        own_we    = ({1'b0, clr_r} < (CLR_W+1)'(NUM_FRAMES));
        own_waddr = FRAME_W'(clr_r);
        pm_we     = ({1'b0, clr_r} < (CLR_W+1)'(PM_DEPTH));
        pm_waddr  = PM_AW'(clr_r);
      end
      S_AEV: begin
        if (own_rdata == '0) begin
          own_we    = 1'b1;
          own_wdata = pid_idx;
          pm_we     = 1'b1;
          pm_wdata  = {1'b1, f_r[FRAME_W-1:0]};
          link_we   = have_prev_r;
        end
      end
      S_AFIN: begin
        link_we    = 1'b1;
        link_wdata = '1;
      end
      S_FEV: begin
        own_we = walk_take;
      end
      S_UNMAP: begin
        pm_we    = unmap_go;
        pm_waddr = {pid_idx, VP_W'(vp_sum)};
      end
      S_LOOKD: begin
        ram_we = look_hit && (op_r == pfa_pkg::OP_WRITE);
      end
      default: begin
      end
    endcase
    // The byte RAM clears alongside the owner table and page map
    if (state_r == S_CLR) begin
      ram_we    = ({1'b0, clr_r} < (CLR_W+1)'(RAM_DEPTH));
      ram_wdata = '0;
    end
  end

  pfa_ram #(.WIDTH(PROC_W), .DEPTH(NUM_FRAMES)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(f_r[FRAME_W-1:0]), .rdata(own_rdata)
  );

  pfa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_FRAMES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(f_r[FRAME_W-1:0]), .rdata(link_rdata)
  );

  pfa_ram #(.WIDTH(LINK_W), .DEPTH(PM_DEPTH)) u_pmap (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata)
  );

  pfa_ram #(.WIDTH(pfa_pkg::DATA_W), .DEPTH(RAM_DEPTH)) u_bytes (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_rd_r, out_addr_r, out_status_r};

  // Request sequencer, break pointers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      free_r       <= CNT_W'(NUM_FRAMES);
      out_tvalid_r <= 1'b0;
      have_prev_r  <= 1'b0;
      for (int p = 0; p < NUM_PROCS; p++) begin
        brk_r[p] <= BRK_W'(pfa_pkg::RESET_BREAK);
      end
    end else begin
      // Drop the result once the transfer completes, unless a new one loads
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + CLR_W'(1);
          if (clr_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r         <= pfa_pkg::op_t'(in_tuser);
            pid_r        <= in_tdata[3:0];
            va_r         <= in_tdata[23:4];
            size_r       <= in_tdata[44:24];
            wd_r         <= in_tdata[52:45];
            res_status_r <= pfa_pkg::ST_OK;
            res_addr_r   <= '0;
            res_rd_r     <= '0;
            state_r      <= (pfa_pkg::op_t'(in_tuser) == pfa_pkg::OP_ALLOC) ? S_ACHK : S_LOOK;
          end
        end
        S_ACHK: begin
          f_r         <= '0;
          k_r         <= '0;
          have_prev_r <= 1'b0;
          if (pid_bad) begin
            res_status_r <= pfa_pkg::ST_NOMEM;
            state_r      <= S_DONE;
          end else if (n_pages == '0) begin
            res_addr_r <= pfa_pkg::ADDR_W'(brk_cur);
            state_r    <= S_DONE;
          end else if ((NB_W'(n_pages) > NB_W'(free_r)) || (nb >= NB_W'(RAM_BYTES)) ||
                       (nb > NB_W'(VSPACE))) begin
            res_status_r <= pfa_pkg::ST_NOMEM;
            state_r      <= S_DONE;
          end else begin
            n_r        <= CNT_W'(n_pages);
            ret_r      <= brk_cur;
            res_addr_r <= pfa_pkg::ADDR_W'(brk_cur);
            if (!cfg_wr_en) begin
              brk_r[pid_idx] <= BRK_W'(nb);
            end
            state_r    <= S_ARD;
          end
        end
        S_ARD: begin
          state_r <= S_AEV;
        end
        S_AEV: begin
          if (own_rdata == '0) begin
            prev_r      <= f_r[FRAME_W-1:0];
            have_prev_r <= 1'b1;
            k_r         <= k_nxt;
          end
          f_r <= f_r + LINK_W'(1);
          if (((own_rdata == '0) && (k_nxt == n_r)) ||
              (f_r == LINK_W'(NUM_FRAMES - 1))) begin
            state_r <= S_AFIN;
          end else begin
            state_r <= S_ARD;
          end
        end
        S_AFIN: begin
          free_r  <= free_r - k_r;
          state_r <= S_DONE;
        end
        S_LOOK: begin
          state_r <= S_LOOKD;
        end
        S_LOOKD: begin
          cnt_r <= '0;
          k_r   <= '0;
          f_r   <= {1'b0, pm_rdata[FRAME_W-1:0]};
          if (!look_hit) begin
            res_status_r <= pfa_pkg::ST_BADVA;
            state_r      <= S_DONE;
          end else begin
            case (op_r)
              pfa_pkg::OP_FREE: state_r <= S_FRD;
              pfa_pkg::OP_READ: state_r <= S_RDD;
              default:          state_r <= S_DONE;
            endcase
          end
        end
        S_RDD: begin
          res_rd_r <= ram_rdata;
          state_r  <= S_DONE;
        end
        S_FRD: begin
          state_r <= S_FEV;
        end
        S_FEV: begin
          if (walk_take) begin
            free_r <= free_r + CNT_W'(1);
            cnt_r  <= cnt_nxt;
            f_r    <= link_rdata;
            if (link_rdata[FRAME_W] || (cnt_nxt == CNT_W'(NUM_FRAMES))) begin
              state_r <= S_UNMAP;
            end else begin
              state_r <= S_FRD;
            end
          end else begin
            state_r <= S_UNMAP;
          end
        end
        S_UNMAP: begin
          k_r <= k_nxt;
          if (!unmap_go) begin
            state_r <= S_FBRK;
          end
        end
        S_FBRK: begin
          if ((fb_lhs == FB_W'(brk_cur)) && !cfg_wr_en) begin
            brk_r[pid_idx] <= brk_cur - BRK_W'(fb_bytes);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            out_rd_r     <= res_rd_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // Load every break pointer from the configuration write
      if (cfg_wr_en) begin
        for (int p = 0; p < NUM_PROCS; p++) begin
          brk_r[p] <= BRK_W'(cfg_wr_data);
        end
      end
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_r) <= NUM_FRAMES)
    else $error("free frame count exceeds the frame table");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AFIN) |-> (k_r == n_r))
    else $error("allocation ended with fewer frames than requested");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the completion state");

  a_walk_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEV && walk_take) |=> (32'(free_r) == $past(32'(free_r)) + 1))
    else $error("released frame not counted as free");

endmodule
